### src/multi_servo_pose_interpolator_macros.svh
// Assertion macros used by the checker of the servo pose interpolator.
`ifndef MULTI_SERVO_POSE_INTERPOLATOR_MACROS_SVH
`define MULTI_SERVO_POSE_INTERPOLATOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define MSPI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MSPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mspi_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the home pose table of the servo pose interpolator.
package mspi_pkg;

    localparam int SERVO_COUNT = 20;
    localparam int IDX_W       = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
    localparam int SERVO_W     = 5;
    localparam int ANGLE_W     = 8;
    localparam int TIME_W      = 16;
    localparam int PERIOD_W    = 8;
    localparam int PROD_W      = ANGLE_W + TIME_W;
    localparam int CNT_W       = $clog2(ANGLE_W);
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [ANGLE_W-1:0]  MAX_DEG        = 8'd180;
    localparam logic [TIME_W-1:0]   DURATION_RESET = 16'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 8'd10;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 8'd1;

    // Servos beyond the twentieth rest at 90 degrees.
    localparam logic [ANGLE_W-1:0] HOME_POSE [32] = '{
        8'd90,  8'd150, 8'd150, 8'd30,  8'd90,  8'd90,  8'd90,  8'd30,
        8'd30,  8'd150, 8'd90,  8'd90,  8'd30,  8'd30,  8'd30,  8'd150,
        8'd150, 8'd150, 8'd90,  8'd90,  8'd90,  8'd90,  8'd90,  8'd90,
        8'd90,  8'd90,  8'd90,  8'd90,  8'd90,  8'd90,  8'd90,  8'd90
    };

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SERVO_W-1:0] servo_sel;
        logic [ANGLE_W-1:0] target_deg;
    } item_t;

    typedef struct packed {
        logic [SERVO_W-1:0] out_servo;
        logic [ANGLE_W-1:0] out_angle;
        logic               last_of_run;
        logic               move_done;
    } result_t;

    typedef struct packed {
        logic               ld_en;
        logic [IDX_W-1:0]   ld_idx;
        logic [ANGLE_W-1:0] ld_deg;
        logic               cp_en;
        logic [IDX_W-1:0]   rd_idx;
    } store_ctrl_t;

    typedef struct packed {
        logic               go;
        logic [ANGLE_W-1:0] start_deg;
        logic [ANGLE_W-1:0] target_deg;
        logic [TIME_W-1:0]  elapsed;
        logic [TIME_W-1:0]  duration;
    } interp_req_t;

    typedef struct packed {
        logic               done;
        logic [ANGLE_W-1:0] angle;
    } interp_rsp_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_EMIT,
        SEQ_CALC,
        SEQ_WAIT
    } seq_state_t;

    typedef enum logic [1:0] {
        IP_IDLE,
        IP_MUL,
        IP_DIV,
        IP_FIN
    } interp_phase_t;

endpackage

### src/multi_servo_pose_interpolator.sv
`timescale 1ns / 1ps
// Top level of the servo pose interpolator: command sequencer, timers and configuration.
//
// A command is taken when start is high and busy is low. Loads, ignored
// commands and ticks that fall between updates leave the sequencer idle. A
// start, or the tick that ends a move, emits one result per servo on
// consecutive cycles. An update tick runs every servo through the bit-serial
// multiply and divide unit, and each result appears as soon as its servo is
// finished. Each result is shown for exactly one cycle with result_valid
// high; the receiver must take it then. The configuration port is always
// ready.
module multi_servo_pose_interpolator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  mspi_pkg::item_t                     item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mspi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mspi_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                result_valid,
    output mspi_pkg::result_t                   result
);

    mspi_pkg::seq_state_t               state_reg, state_next;
    logic [mspi_pkg::IDX_W-1:0]         idx_reg, idx_next;
    logic                               final_reg, final_next;
    logic                               moving_reg, moving_next;
    logic [mspi_pkg::TIME_W-1:0]        elapsed_reg, elapsed_next;
    logic [mspi_pkg::PERIOD_W-1:0]      period_reg, period_next;
    logic [mspi_pkg::TIME_W-1:0]        duration_reg, duration_next;
    logic [mspi_pkg::PERIOD_W-1:0]      update_reg, update_next;
    logic                               result_valid_reg, result_valid_next;
    mspi_pkg::result_t                  result_reg, result_next;

    mspi_pkg::store_ctrl_t              store_ctrl;
    logic [mspi_pkg::ANGLE_W-1:0]       start_deg;
    logic [mspi_pkg::ANGLE_W-1:0]       target_deg;
    mspi_pkg::interp_req_t              ireq;
    mspi_pkg::interp_rsp_t              irsp;

    logic                               accept;
    logic                               last_servo;
    logic                               sel_in_range;
    logic [mspi_pkg::TIME_W-1:0]        elapsed_inc;
    logic [mspi_pkg::PERIOD_W-1:0]      period_inc;

    mspi_pose_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (store_ctrl),
        .start_deg  (start_deg),
        .target_deg (target_deg)
    );

    mspi_interp u_interp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ireq),
        .rsp   (irsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mspi_pkg::SEQ_IDLE;
            idx_reg          <= '0;
            final_reg        <= 1'b0;
            moving_reg       <= 1'b0;
            elapsed_reg      <= '0;
            period_reg       <= '0;
            duration_reg     <= mspi_pkg::DURATION_RESET;
            update_reg       <= mspi_pkg::PERIOD_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            final_reg        <= final_next;
            moving_reg       <= moving_next;
            elapsed_reg      <= elapsed_next;
            period_reg       <= period_next;
            duration_reg     <= duration_next;
            update_reg       <= update_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy         = (state_reg != mspi_pkg::SEQ_IDLE);
    assign accept       = start && !busy;
    assign last_servo   = (idx_reg == mspi_pkg::IDX_W'(mspi_pkg::SERVO_COUNT - 1));
    assign sel_in_range = ({1'b0, item.servo_sel} <
                           (mspi_pkg::SERVO_W + 1)'(mspi_pkg::SERVO_COUNT));
    // Both timers saturate at their all-ones value.
    assign elapsed_inc  = elapsed_reg + mspi_pkg::TIME_W'(elapsed_reg != '1);
    assign period_inc   = period_reg + mspi_pkg::PERIOD_W'(period_reg != '1);

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        final_next        = final_reg;
        moving_next       = moving_reg;
        elapsed_next      = elapsed_reg;
        period_next       = period_reg;
        duration_next     = duration_reg;
        update_next       = update_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;

        store_ctrl.ld_en  = 1'b0;
        store_ctrl.ld_idx = item.servo_sel[mspi_pkg::IDX_W-1:0];
        store_ctrl.ld_deg = (item.target_deg > mspi_pkg::MAX_DEG) ?
                            mspi_pkg::MAX_DEG : item.target_deg;
        store_ctrl.cp_en  = 1'b0;
        store_ctrl.rd_idx = idx_reg;

        ireq.go         = 1'b0;
        ireq.start_deg  = start_deg;
        ireq.target_deg = target_deg;
        ireq.elapsed    = elapsed_reg;
        ireq.duration   = duration_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                mspi_pkg::CFG_DURATION: duration_next = cfg_data[mspi_pkg::TIME_W-1:0];
                mspi_pkg::CFG_PERIOD:   update_next   = cfg_data[mspi_pkg::PERIOD_W-1:0];
                default:                ;
            endcase
        end

        unique case (state_reg)
            mspi_pkg::SEQ_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.cmd)
                        mspi_pkg::CMD_LOAD:
                        begin
                            store_ctrl.ld_en = !moving_reg && sel_in_range;
                        end
                        mspi_pkg::CMD_START:
                        begin
                            if (!moving_reg)
                            begin
                                moving_next  = 1'b1;
                                elapsed_next = '0;
                                period_next  = '0;
                                final_next   = 1'b0;
                                idx_next     = '0;
                                state_next   = mspi_pkg::SEQ_EMIT;
                            end
                        end
                        mspi_pkg::CMD_TICK:
                        begin
                            if (moving_reg)
                            begin
                                if (elapsed_inc >= duration_reg)
                                begin
                                    moving_next  = 1'b0;
                                    elapsed_next = '0;
                                    period_next  = '0;
                                    final_next   = 1'b1;
                                    idx_next     = '0;
                                    state_next   = mspi_pkg::SEQ_EMIT;
                                end
                                else if (period_inc >= update_reg)
                                begin
                                    elapsed_next = elapsed_inc;
                                    period_next  = '0;
                                    idx_next     = '0;
                                    state_next   = mspi_pkg::SEQ_CALC;
                                end
                                else
                                begin
                                    elapsed_next = elapsed_inc;
                                    period_next  = period_inc;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            mspi_pkg::SEQ_EMIT:
            begin
                // Start pose, or final target pose copied into the start angles.
                result_valid_next       = 1'b1;
                result_next.out_servo   = mspi_pkg::SERVO_W'(idx_reg);
                result_next.out_angle   = final_reg ? target_deg : start_deg;
                result_next.last_of_run = last_servo;
                result_next.move_done   = final_reg;
                store_ctrl.cp_en        = final_reg;
                if (last_servo)
                begin
                    state_next = mspi_pkg::SEQ_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            mspi_pkg::SEQ_CALC:
            begin
                ireq.go    = 1'b1;
                state_next = mspi_pkg::SEQ_WAIT;
            end
            mspi_pkg::SEQ_WAIT:
            begin
                if (irsp.done)
                begin
                    result_valid_next       = 1'b1;
                    result_next.out_servo   = mspi_pkg::SERVO_W'(idx_reg);
                    result_next.out_angle   = irsp.angle;
                    result_next.last_of_run = last_servo;
                    result_next.move_done   = 1'b0;
                    if (last_servo)
                    begin
                        state_next = mspi_pkg::SEQ_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = mspi_pkg::SEQ_CALC;
                    end
                end
            end
            default:
            begin
                state_next = mspi_pkg::SEQ_IDLE;
            end
        endcase
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### src/mspi_pose_store.sv
`timescale 1ns / 1ps
// Start and target angle registers for every servo, reset to the home pose.
module mspi_pose_store (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mspi_pkg::store_ctrl_t               ctrl,
    output logic [mspi_pkg::ANGLE_W-1:0]        start_deg,
    output logic [mspi_pkg::ANGLE_W-1:0]        target_deg
);

    logic [mspi_pkg::ANGLE_W-1:0] start_reg  [mspi_pkg::SERVO_COUNT];
    logic [mspi_pkg::ANGLE_W-1:0] target_reg [mspi_pkg::SERVO_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mspi_pkg::SERVO_COUNT; i++)
            begin
                start_reg[i]  <= mspi_pkg::HOME_POSE[i];
                target_reg[i] <= mspi_pkg::HOME_POSE[i];
            end
        end
        else
        begin
            if (ctrl.ld_en)
            begin
                target_reg[ctrl.ld_idx] <= ctrl.ld_deg;
            end
            // At the end of a move the target becomes the next start angle.
            if (ctrl.cp_en)
            begin
                start_reg[ctrl.rd_idx] <= target_reg[ctrl.rd_idx];
            end
        end
    end

    assign start_deg  = start_reg[ctrl.rd_idx];
    assign target_deg = target_reg[ctrl.rd_idx];

endmodule

### src/mspi_interp.sv
`timescale 1ns / 1ps
// Bit-serial interpolation unit: start + trunc((target - start) * elapsed / duration).
module mspi_interp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mspi_pkg::interp_req_t req,
    output mspi_pkg::interp_rsp_t rsp
);

    mspi_pkg::interp_phase_t              phase_reg, phase_next;
    logic [mspi_pkg::CNT_W-1:0]           cnt_reg, cnt_next;
    logic                                 done_reg, done_next;
    logic                                 neg_reg, neg_next;
    logic [mspi_pkg::ANGLE_W-1:0]         base_reg, base_next;
    logic [mspi_pkg::ANGLE_W-1:0]         mag_reg, mag_next;
    logic [mspi_pkg::TIME_W-1:0]          mcand_reg, mcand_next;
    logic [mspi_pkg::TIME_W-1:0]          dur_reg, dur_next;
    logic [mspi_pkg::PROD_W-1:0]          acc_reg, acc_next;
    logic [mspi_pkg::TIME_W-1:0]          rem_reg, rem_next;
    logic [mspi_pkg::ANGLE_W-1:0]         quo_reg, quo_next;
    logic [mspi_pkg::ANGLE_W-1:0]         angle_reg, angle_next;
    logic [mspi_pkg::TIME_W:0]            shifted;
    logic                                 last_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mspi_pkg::IP_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        base_reg  <= base_next;
        mag_reg   <= mag_next;
        mcand_reg <= mcand_next;
        dur_reg   <= dur_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        angle_reg <= angle_next;
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        base_next  = base_reg;
        mag_next   = mag_reg;
        mcand_next = mcand_reg;
        dur_next   = dur_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        angle_next = angle_reg;
        last_step  = (cnt_reg == mspi_pkg::CNT_W'(mspi_pkg::ANGLE_W - 1));
        shifted    = {rem_reg, acc_reg[mspi_pkg::ANGLE_W-1]};

        unique case (phase_reg)
            mspi_pkg::IP_IDLE:
            begin
                if (req.go)
                begin
                    neg_next   = (req.target_deg < req.start_deg);
                    mag_next   = (req.target_deg < req.start_deg) ?
                                 (req.start_deg - req.target_deg) :
                                 (req.target_deg - req.start_deg);
                    base_next  = req.start_deg;
                    mcand_next = req.elapsed;
                    dur_next   = req.duration;
                    acc_next   = '0;
                    cnt_next   = '0;
                    phase_next = mspi_pkg::IP_MUL;
                end
            end
            mspi_pkg::IP_MUL:
            begin
                // Shift-and-add, most significant multiplier bit first.
                acc_next = {acc_reg[mspi_pkg::PROD_W-2:0], 1'b0} +
                           (mag_reg[mspi_pkg::ANGLE_W-1] ?
                            mspi_pkg::PROD_W'(mcand_reg) : '0);
                mag_next = {mag_reg[mspi_pkg::ANGLE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    // Elapsed is below the duration, so the upper part of the
                    // product is already below the divisor.
                    rem_next   = acc_next[mspi_pkg::PROD_W-1:mspi_pkg::ANGLE_W];
                    quo_next   = '0;
                    cnt_next   = '0;
                    phase_next = mspi_pkg::IP_DIV;
                end
            end
            mspi_pkg::IP_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                if (shifted >= {1'b0, dur_reg})
                begin
                    rem_next = mspi_pkg::TIME_W'(shifted - {1'b0, dur_reg});
                    quo_next = {quo_reg[mspi_pkg::ANGLE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[mspi_pkg::TIME_W-1:0];
                    quo_next = {quo_reg[mspi_pkg::ANGLE_W-2:0], 1'b0};
                end
                acc_next = {acc_reg[mspi_pkg::PROD_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    phase_next = mspi_pkg::IP_FIN;
                end
            end
            mspi_pkg::IP_FIN:
            begin
                angle_next = neg_reg ? (base_reg - quo_reg) : (base_reg + quo_reg);
                done_next  = 1'b1;
                phase_next = mspi_pkg::IP_IDLE;
            end
            default:
            begin
                phase_next = mspi_pkg::IP_IDLE;
            end
        endcase
    end

    assign rsp.done  = done_reg;
    assign rsp.angle = angle_reg;

endmodule

### src/mspi_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the servo pose interpolator, bound to the top level.
`include "multi_servo_pose_interpolator_macros.svh"

module mspi_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              busy,
    input logic              result_valid,
    input mspi_pkg::result_t result
);

    // The last result of a set always belongs to the highest servo, and only it.
    `MSPI_ASSERT_SAME(a_last_servo, result_valid, result.last_of_run == (result.out_servo == mspi_pkg::SERVO_W'(mspi_pkg::SERVO_COUNT - 1)), "last_of_run does not match the last servo")
    // Every result angle stays within the servo's range.
    `MSPI_ASSERT_SAME(a_angle_range, result_valid, result.out_angle <= mspi_pkg::MAX_DEG, "angle above the maximum")
    // A set still being emitted keeps the block busy.
    `MSPI_ASSERT_SAME(a_busy_in_set, result_valid && !result.last_of_run, busy, "command accepted in the middle of a result set")
    // The final pose comes out as an unbroken burst.
    `MSPI_ASSERT_NEXT(a_final_burst, result_valid && result.move_done && !result.last_of_run, result_valid && result.move_done, "final pose set interrupted")

endmodule

bind multi_servo_pose_interpolator mspi_checker u_mspi_checker (.*);
